### rtl/banknote_greedy_dispenser_macros.svh
// assertion macros for the banknote dispenser
`ifndef BANKNOTE_GREEDY_DISPENSER_MACROS_SVH
`define BANKNOTE_GREEDY_DISPENSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BGD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bgd_pkg.sv
// shared types, codes and constants for the banknote dispenser
package bgd_pkg;

    localparam int NUM_DENOMS  = 7;
    localparam int VALUE_BITS  = 24;
    localparam int QTY_BITS    = 16;
    localparam int DENOM_BITS  = 7;
    localparam int SUM_EXTRA   = 8;

    localparam int DENOMS [NUM_DENOMS] = '{1, 2, 5, 10, 20, 50, 100};

    localparam logic [VALUE_BITS-1:0] BAL_MAX = '1;

    localparam logic [1:0] REQ_LOAD     = 2'd0;
    localparam logic [1:0] REQ_CHECK    = 2'd1;
    localparam logic [1:0] REQ_WITHDRAW = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNPAYABLE = 2'd1;
    localparam logic [1:0] STAT_BAD_DENOM = 2'd2;

    typedef enum logic
    {
        TOK_LOAD,
        TOK_PASS
    } tok_op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } state_t;

    typedef struct packed
    {
        logic [1:0]            req_type;
        logic [QTY_BITS-1:0]   quantity;
        logic [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed
    {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] balance;
    } rsp_t;

    // token handed from cell to cell
    typedef struct packed
    {
        logic                  valid;
        tok_op_t               op;
        logic [QTY_BITS-1:0]   qty;
        logic [VALUE_BITS-1:0] rem;
    } tok_t;

    function automatic logic is_denom(input logic [VALUE_BITS-1:0] val);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_DENOMS; i++)
        begin
            if (val == VALUE_BITS'(DENOMS[i]))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### rtl/bgd_cell.sv
// one denomination cell: holds a note count, two register stages per token
module bgd_cell
    import bgd_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int DENOM      = 1
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tok_t                            tok_in,
    input  logic [COUNT_BITS+SUM_EXTRA-1:0] delta_in,
    input  logic                            commit,
    output tok_t                            tok_out,
    output logic [COUNT_BITS+SUM_EXTRA-1:0] delta_out
);

    localparam int RW  = VALUE_BITS;
    localparam int SW  = COUNT_BITS + SUM_EXTRA;
    localparam int K   = RW + $clog2(DENOM);
    localparam int MW  = RW + 1;
    localparam int PRW = RW + MW;
    localparam longint unsigned MAG =
        ((64'd1 << K) + 64'(DENOM) - 64'd1) / 64'(DENOM);
    localparam logic [MW-1:0] MAGIC = MW'(MAG);
    localparam int WW = (COUNT_BITS > RW) ? COUNT_BITS : RW;
    localparam int TW = (COUNT_BITS < RW) ? COUNT_BITS : RW;
    localparam int QW = (COUNT_BITS > QTY_BITS) ? COUNT_BITS : QTY_BITS;
    localparam int AW = (COUNT_BITS < QTY_BITS) ? COUNT_BITS : QTY_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [TW-1:0]         take_reg;

    logic                  s1_valid_reg;
    tok_op_t               s1_op_reg;
    logic [QTY_BITS-1:0]   s1_qty_reg;
    logic [RW-1:0]         s1_rem_reg;
    logic [RW-1:0]         s1_q_reg;
    logic [AW-1:0]         s1_add_reg;
    logic [SW-1:0]         s1_delta_reg;

    tok_t                  tok_reg, tok_next;
    logic [SW-1:0]         delta_reg, delta_next;

    logic [PRW-1:0]        quot_prod;
    logic [RW-1:0]         quot;
    logic [COUNT_BITS-1:0] room;
    logic [QW-1:0]         add_w;
    logic [AW-1:0]         add_amt;
    logic                  match;
    logic [WW-1:0]         take_w;
    logic [TW-1:0]         take;
    logic [TW+DENOM_BITS-1:0] pay;
    logic [AW+DENOM_BITS-1:0] add_val;

    // stage one: exact quotient by reciprocal, load room
    always_comb
    begin
        quot_prod = PRW'(tok_in.rem) * PRW'(MAGIC);
        quot      = RW'(quot_prod >> K);
        room      = CMAX - count_reg;
        add_w     = (QW'(tok_in.qty) > QW'(room)) ? QW'(room) : QW'(tok_in.qty);
        add_amt   = AW'(add_w);
        match     = (tok_in.op == TOK_LOAD) && (tok_in.rem == RW'(DENOM));
    end

    // stage two: notes taken, remainder and balance delta
    always_comb
    begin
        take_w  = (WW'(count_reg) < WW'(s1_q_reg)) ? WW'(count_reg) : WW'(s1_q_reg);
        take    = TW'(take_w);
        pay     = (TW+DENOM_BITS)'(take) * (TW+DENOM_BITS)'(DENOM);
        add_val = (AW+DENOM_BITS)'(s1_add_reg) * (AW+DENOM_BITS)'(DENOM);

        tok_next.valid = s1_valid_reg;
        tok_next.op    = s1_op_reg;
        tok_next.qty   = s1_qty_reg;
        tok_next.rem   = (s1_op_reg == TOK_PASS) ? (s1_rem_reg - RW'(pay)) : s1_rem_reg;
        delta_next     = s1_delta_reg + SW'(add_val);

        count_next = count_reg;
        if (commit)
        begin
            count_next = count_reg - COUNT_BITS'(take_reg);
        end
        else if (s1_valid_reg && (s1_op_reg == TOK_LOAD))
        begin
            count_next = count_reg + COUNT_BITS'(s1_add_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            tok_reg      <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= tok_in.valid;
            tok_reg      <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= tok_in.op;
        s1_qty_reg   <= tok_in.qty;
        s1_rem_reg   <= tok_in.rem;
        s1_q_reg     <= quot;
        s1_add_reg   <= match ? add_amt : '0;
        s1_delta_reg <= delta_in;
        delta_reg    <= delta_next;
        if (s1_valid_reg && (s1_op_reg == TOK_PASS))
        begin
            take_reg <= take;
        end
    end

    assign tok_out   = tok_reg;
    assign delta_out = delta_reg;

endmodule

### rtl/banknote_greedy_dispenser.sv
// top level of the banknote dispenser: request control, cell chain, balance
// Holds a note count for each of the seven denominations 1, 2, 5, 10, 20, 50
// and 100, all cleared at reset. One request is worked at a time and every
// request returns exactly one response with a status and the balance after
// it. A request travels as a token down a chain of seven cells, largest note
// first; each cell owns one count and spends two register stages on the token
// (exact quotient by a reciprocal multiply, then the notes taken and the new
// remainder). A response is ready once the token leaves the last cell, and
// the next request can be taken in the cycle after that response is loaded
// into the output register. A load adds a saturated quantity to the
// matching cell and the added value to an exact running sum; a value that
// is no denomination changes nothing and returns status bad denomination.
// Check, withdraw and the reserved fourth code run the greedy pass; a
// payable withdraw then decrements every cell together on commit. The
// reported balance saturates at the top of its 24-bit range while the cells
// keep their true counts. A finished response sits in an output register, so
// a stalled response side only holds the block once a second response is due.
module banknote_greedy_dispenser
    import bgd_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

`include "banknote_greedy_dispenser_macros.svh"

    localparam int SW = COUNT_BITS + SUM_EXTRA;
    localparam int BW = (SW > VALUE_BITS) ? SW : VALUE_BITS;

    state_t        state_reg, state_next;
    req_t          cmd_reg;
    tok_t          inj_reg;
    logic [SW-1:0] sum_reg, sum_next;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;
    rsp_t          pend_reg;

    // token chain, index 0 feeds the largest note
    tok_t          chain [NUM_DENOMS+1];
    logic [SW-1:0] dchain [NUM_DENOMS+1];

    logic          req_accept;
    logic          done;
    logic          is_load;
    logic          payable;
    logic          commit;
    logic          out_free;
    logic          rsp_load;
    rsp_t          fresh;
    tok_t          inj_next;

    assign chain[0]  = inj_reg;
    assign dchain[0] = '0;

    for (genvar k = 0; k < NUM_DENOMS; k++)
    begin : g_cell
        bgd_cell #(
            .COUNT_BITS (COUNT_BITS),
            .DENOM      (DENOMS[NUM_DENOMS-1-k])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (chain[k]),
            .delta_in  (dchain[k]),
            .commit    (commit),
            .tok_out   (chain[k+1]),
            .delta_out (dchain[k+1])
        );
    end

    // end of chain: status, commit and the new sum
    always_comb
    begin
        done    = chain[NUM_DENOMS].valid;
        is_load = (cmd_reg.req_type == REQ_LOAD);
        payable = (chain[NUM_DENOMS].rem == '0);
        commit  = done && !is_load && (cmd_reg.req_type == REQ_WITHDRAW) && payable;

        sum_next = sum_reg;
        if (done && is_load)
        begin
            sum_next = sum_reg + dchain[NUM_DENOMS];
        end
        else if (commit)
        begin
            // payable means the amount is covered by the held notes
            sum_next = sum_reg - SW'(cmd_reg.value);
        end

        if (is_load)
        begin
            fresh.status = is_denom(cmd_reg.value) ? STAT_OK : STAT_BAD_DENOM;
        end
        else
        begin
            fresh.status = payable ? STAT_OK : STAT_UNPAYABLE;
        end
        fresh.balance = (BW'(sum_next) > BW'(BAL_MAX)) ? BAL_MAX : VALUE_BITS'(sum_next);
    end

    // request control
    always_comb
    begin
        state_next = state_reg;
        req_stall  = (state_reg != ST_IDLE);
        req_accept = req_valid && !req_stall;
        out_free   = !rsp_valid_reg || !rsp_stall;
        rsp_load   = 1'b0;

        inj_next.valid = req_accept;
        inj_next.op    = (req.req_type == REQ_LOAD) ? TOK_LOAD : TOK_PASS;
        inj_next.qty   = req.quantity;
        inj_next.rem   = req.value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (done)
                begin
                    rsp_load   = out_free;
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                rsp_load = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inj_reg       <= '0;
            sum_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= inj_next;
            sum_reg   <= sum_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            cmd_reg <= req;
        end
        if (done)
        begin
            pend_reg <= fresh;
        end
        if (rsp_load)
        begin
            rsp_reg <= done ? fresh : pend_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a token reaches the chain end only while a request is in flight
    `BGD_ASSERT_SAME(a_tail_busy, done, state_reg == ST_BUSY, "token left chain while not busy")
    // an accepted request enters the chain in the next cycle
    `BGD_ASSERT_NEXT(a_inject, req_accept, inj_reg.valid && state_reg == ST_BUSY, "request not injected")
    // cells are decremented only for a fully paid amount
    `BGD_ASSERT_SAME(a_commit_paid, commit, payable && done, "commit without payable amount")
    // a held response waits behind an occupied output register
    `BGD_ASSERT_SAME(a_hold_full, state_reg == ST_HOLD, rsp_valid_reg, "hold with empty output")

endmodule

### tb/sv/banknote_greedy_dispenser_test.sv
// self-checking testbench for the banknote dispenser: random requests, greedy model, scoreboard
`timescale 1ns / 100ps

module banknote_greedy_dispenser_test;
    import bgd_pkg::*;

    // count width the block is built with
    localparam int COUNT_W = 16;
    localparam longint COUNT_TOP = (64'd1 << COUNT_W) - 1;

    // the package names three request types; the fourth code acts as a check
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam int RANDOM_REQS = 1000;
    localparam int MAX_GAP = 10;
    localparam int MISMATCH_SHOW = 10;
    // slowest run: ~1021 requests, each with the longest gap, the chain and the longest
    // stall, plus the long hold, taken about ten times over
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AFTER = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // requests waiting to be offered, responses the model says are due
    req_t pending_reqs[$];
    rsp_t due_rsps[$];

    // model of the note store: counts per denomination, ascending order
    logic [COUNT_W-1:0] vault_notes [NUM_DENOMS];

    int send_gap;
    int recv_gap;
    int sent_count;
    int rsp_count;
    int mismatches;
    int cycle_count;
    logic long_hold = 1'b0;
    rsp_t wanted;

    // what the run covered
    int loads_seen;
    int bad_denoms_seen;
    int passes_seen;
    int paid_withdrawals;
    int unpayable_seen;

    banknote_greedy_dispenser #(.COUNT_BITS(COUNT_W)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle cycles before the next request or after a response; quiet stretches use none
    function automatic int pick_gap(input bit quiet);
        if (quiet)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // greedy dispenser model: applies one request to the note store and
    // returns the response it must produce
    function automatic rsp_t settle_request(input req_t r);
        rsp_t result;
        int slot;
        longint rest;
        longint want;
        longint sum;
        longint taken [NUM_DENOMS];
        result.status = STAT_OK;
        slot = -1;
        if (r.req_type == REQ_LOAD)
        begin
            loads_seen++;
            for (int i = 0; i < NUM_DENOMS; i++)
            begin
                if (r.value == VALUE_BITS'(DENOMS[i]))
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                result.status = STAT_BAD_DENOM;
                bad_denoms_seen++;
            end
            else
            begin
                // counts stop at the top of their range
                sum = longint'(vault_notes[slot]) + longint'(r.quantity);
                vault_notes[slot] = (sum > COUNT_TOP) ? COUNT_TOP[COUNT_W-1:0]
                                                      : sum[COUNT_W-1:0];
            end
        end
        else
        begin
            // check, withdraw and the reserved code all run the pass
            passes_seen++;
            rest = longint'(r.value);
            for (int i = NUM_DENOMS - 1; i >= 0; i--)
            begin
                want = rest / DENOMS[i];
                taken[i] = (want < longint'(vault_notes[i])) ? want
                                                             : longint'(vault_notes[i]);
                rest = rest - taken[i] * DENOMS[i];
            end
            if (rest != 0)
            begin
                result.status = STAT_UNPAYABLE;
                unpayable_seen++;
            end
            else if (r.req_type == REQ_WITHDRAW)
            begin
                paid_withdrawals++;
                for (int i = 0; i < NUM_DENOMS; i++)
                begin
                    vault_notes[i] = vault_notes[i] - COUNT_W'(taken[i]);
                end
            end
        end
        // reported balance saturates, counts stay exact
        sum = 0;
        for (int i = 0; i < NUM_DENOMS; i++)
        begin
            sum = sum + longint'(vault_notes[i]) * DENOMS[i];
        end
        result.balance = (sum > longint'(BAL_MAX)) ? BAL_MAX : sum[VALUE_BITS-1:0];
        return result;
    endfunction

    task automatic queue_req(input logic [1:0] kind, input int qty, input int amount);
        req_t item;
        item.req_type = kind;
        item.quantity = QTY_BITS'(qty);
        item.value = VALUE_BITS'(amount);
        pending_reqs.push_back(item);
    endtask

    // request side: offer queued requests with random gaps, feed the model
    // on every accepted request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap = 0;
            sent_count = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                due_rsps.push_back(settle_request(req));
                sent_count++;
                // every fourth stretch of 80 requests goes back to back
                send_gap = pick_gap((sent_count / 80) % 4 == 3);
            end
            // slot is free once the offered request is taken or nothing is offered
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response side stall: a random pause after each response, plus the long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                recv_gap = pick_gap((rsp_count / 100) % 4 == 1);
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
            end
            rsp_stall <= long_hold || (recv_gap > 0);
        end
    end

    // long hold: the sender keeps offering, the output register and the held response
    // fill up and the block has to stall its request side
    initial
    begin
        wait (rsp_count >= HOLD_AFTER);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // response monitor: compare each accepted response with the oldest one due
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_count = 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            rsp_count++;
            if (due_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOW)
                begin
                    $display("response %0d with none due: status %0d balance %0d",
                             rsp_count, rsp.status, rsp.balance);
                end
            end
            else
            begin
                wanted = due_rsps.pop_front();
                if (rsp.status !== wanted.status || rsp.balance !== wanted.balance)
                begin
                    mismatches++;
                    if (mismatches <= MISMATCH_SHOW)
                    begin
                        $display("response %0d: status %0d expected %0d, balance %0d expected %0d",
                                 rsp_count, rsp.status, wanted.status,
                                 rsp.balance, wanted.balance);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still due",
                     cycle_count, due_rsps.size());
            $display("banknote_greedy_dispenser_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int amount_sel;
        int qty;
        int amount;
        logic [1:0] kind;

        rst_n = 1'b0;
        cycle_count = 0;
        mismatches = 0;
        loads_seen = 0;
        bad_denoms_seen = 0;
        passes_seen = 0;
        paid_withdrawals = 0;
        unpayable_seen = 0;
        for (int i = 0; i < NUM_DENOMS; i++)
        begin
            vault_notes[i] = '0;
        end

        // directed part
        // empty store: zero amount is payable, anything else is not
        queue_req(REQ_CHECK, 16'hA5A5, 0);
        queue_req(REQ_WITHDRAW, 0, 1);
        // values that are no denomination
        queue_req(REQ_LOAD, 5, 0);
        queue_req(REQ_LOAD, 5, 3);
        queue_req(REQ_LOAD, 16'hFFFF, 24'hFFFFFF);
        // zero quantity of a real note
        queue_req(REQ_LOAD, 0, 1);
        // greedy trap: one 5 and three 2s cannot make 6 greedily
        queue_req(REQ_LOAD, 3, 2);
        queue_req(REQ_LOAD, 1, 5);
        queue_req(REQ_CHECK, 0, 6);
        queue_req(REQ_WITHDRAW, 0, 6);
        queue_req(REQ_WITHDRAW, 16'hFFFF, 9);
        // fill the large notes to the top, then push past it
        queue_req(REQ_LOAD, 16'hFFFF, 100);
        queue_req(REQ_LOAD, 1, 100);
        queue_req(REQ_LOAD, 16'hFFFF, 50);
        queue_req(REQ_LOAD, 16'hFFFF, 20);
        queue_req(REQ_LOAD, 16'hFFFF, 10);
        queue_req(REQ_LOAD, 7, 1);
        queue_req(REQ_RESERVED, 16'h5A5A, 123);
        // largest amount, then a big payable one, then zero withdraw
        queue_req(REQ_WITHDRAW, 0, 24'hFFFFFF);
        queue_req(REQ_WITHDRAW, 0, 1234567);
        queue_req(REQ_WITHDRAW, 0, 0);

        // random part: mostly valid loads and payouts of moderate size
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            qty = $urandom_range(0, 65535);
            amount_sel = $urandom_range(0, 9);
            if (amount_sel == 0)
            begin
                amount = 0;
            end
            else if (amount_sel == 1)
            begin
                amount = $urandom_range(0, 24'hFFFFFF);
            end
            else if (amount_sel < 6)
            begin
                amount = $urandom_range(0, 500);
            end
            else
            begin
                amount = $urandom_range(0, 100000);
            end
            if (pick < 35)
            begin
                kind = REQ_LOAD;
                if ($urandom_range(0, 19) != 0)
                begin
                    qty = $urandom_range(0, 40);
                end
                if (pick < 32)
                begin
                    amount = DENOMS[$urandom_range(0, NUM_DENOMS - 1)];
                end
            end
            else if (pick < 55)
            begin
                kind = REQ_CHECK;
            end
            else if (pick < 95)
            begin
                kind = REQ_WITHDRAW;
            end
            else
            begin
                kind = REQ_RESERVED;
            end
            queue_req(kind, qty, amount);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // everything offered and taken, then every response back
        while (pending_reqs.size() > 0 || req_valid)
        begin
            @(posedge clk);
        end
        while (due_rsps.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d loads (%0d bad denominations), %0d greedy passes",
                 sent_count, loads_seen, bad_denoms_seen, passes_seen);
        $display("%0d paid withdrawals, %0d unpayable amounts, %0d mismatches",
                 paid_withdrawals, unpayable_seen, mismatches);
        if (mismatches == 0 && due_rsps.size() == 0)
        begin
            $display("banknote_greedy_dispenser_test: PASS");
        end
        else
        begin
            $display("banknote_greedy_dispenser_test: FAIL");
        end
        $finish;
    end

endmodule
